// ===== hdl/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and the UTF-8 sequence encoder for the UTF-16 to UTF-8
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

	localparam logic [15:0] HI_BASE   = 16'hD800;
	localparam logic [15:0] HI_LAST   = 16'hDBFF;
	localparam logic [15:0] LO_BASE   = 16'hDC00;
	localparam logic [15:0] LO_LAST   = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [16:0] CAP_RESET = 17'h10000;
	localparam logic [2:0]  LEN_PEND  = 3'd3;

	typedef logic [7:0] octet_t;

	typedef struct packed {
		logic [2:0]        len;
		logic [3:0][7:0]   b;
	} seq_t;

	typedef struct packed {
		logic [5:0][7:0]   bytes;
		logic [2:0]        cnt;
		logic              is_end;
		logic              trunc;
	} pack_t;

	typedef struct packed {
		logic [9:0]        ph;
		logic              have;
		logic [16:0]       bw;
		logic              stopped;
	} state_t;

	function automatic seq_t enc_cp(input logic [20:0] cp);
		seq_t s;
		s.b = '0;
		if (cp < 21'h80) begin
			s.len  = 3'd1;
			s.b[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			s.len  = 3'd2;
			s.b[0] = {3'b110, cp[10:6]};
			s.b[1] = {2'b10, cp[5:0]};
		end else if (cp < SUPP_BASE) begin
			s.len  = 3'd3;
			s.b[0] = {4'b1110, cp[15:12]};
			s.b[1] = {2'b10, cp[11:6]};
			s.b[2] = {2'b10, cp[5:0]};
		end else begin
			s.len  = 3'd4;
			s.b[0] = {5'b11110, cp[20:18]};
			s.b[1] = {2'b10, cp[17:12]};
			s.b[2] = {2'b10, cp[11:6]};
			s.b[3] = {2'b10, cp[5:0]};
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/u16u8_pack.sv =====
// ----------------------------------------------------------------------------
// u16u8_pack
// Builds the byte group for one code unit and the next converter state.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_pack (
	input  wire logic [15:0]       code_unit,
	input  wire logic              is_end,
	input  wire logic [16:0]       capacity,
	input  wire u16u8_pkg::state_t st,
	output u16u8_pkg::state_t      st_nxt,
	output u16u8_pkg::pack_t       pack
);

	logic              is_hi;
	logic              is_lo;
	logic              has_a;
	logic              has_b;
	logic              hold_hi;
	u16u8_pkg::seq_t   seq_a;
	u16u8_pkg::seq_t   seq_b;
	logic [20:0]       pair_cp;
	logic [17:0]       sum_a;
	logic [17:0]       sum_b;
	logic [16:0]       bw1;
	logic              fit_a;
	logic              fit_b;
	logic              emit_a;
	logic              emit_b;
	logic              stop1;
	logic              stop2;
	logic [2:0]        len_b;

	always_comb begin
		is_hi   = (code_unit >= u16u8_pkg::HI_BASE) && (code_unit <= u16u8_pkg::HI_LAST);
		is_lo   = (code_unit >= u16u8_pkg::LO_BASE) && (code_unit <= u16u8_pkg::LO_LAST);
		pair_cp = 21'({st.ph, code_unit[9:0]}) + u16u8_pkg::SUPP_BASE;
		seq_a   = u16u8_pkg::enc_cp({5'd0, 6'b110110, st.ph});

		// pending high goes out alone unless a low surrogate pairs with it
		has_a   = st.have && (is_end || !is_lo);
		hold_hi = !is_end && is_hi && !(st.have && is_lo);
		has_b   = !is_end && !hold_hi;
		if (st.have && is_lo) begin
			seq_b = u16u8_pkg::enc_cp(pair_cp);
		end else begin
			seq_b = u16u8_pkg::enc_cp({5'd0, code_unit});
		end

		sum_a  = {1'b0, st.bw} + 18'(u16u8_pkg::LEN_PEND);
		fit_a  = sum_a < {1'b0, capacity};
		emit_a = has_a && !st.stopped && fit_a;
		stop1  = st.stopped || (has_a && !fit_a);
		bw1    = emit_a ? sum_a[16:0] : st.bw;

		sum_b  = {1'b0, bw1} + 18'(seq_b.len);
		fit_b  = sum_b < {1'b0, capacity};
		emit_b = has_b && !stop1 && fit_b;
		stop2  = stop1 || (has_b && !fit_b);

		// terminator rides in the second slot on the end item
		if (is_end) begin
			len_b = 3'd1;
		end else if (emit_b) begin
			len_b = seq_b.len;
		end else begin
			len_b = 3'd0;
		end

		pack.is_end = is_end;
		pack.trunc  = is_end && stop1;
		if (emit_a) begin
			pack.cnt   = u16u8_pkg::LEN_PEND + len_b;
			pack.bytes = {is_end ? 24'd0 : {seq_b.b[2], seq_b.b[1], seq_b.b[0]},
				seq_a.b[2], seq_a.b[1], seq_a.b[0]};
		end else begin
			pack.cnt   = len_b;
			pack.bytes = {16'd0, is_end ? 32'd0 : seq_b.b};
		end

		if (is_end) begin
			st_nxt = '0;
		end else begin
			st_nxt.ph      = hold_hi ? code_unit[9:0] : 10'd0;
			st_nxt.have    = hold_hi;
			st_nxt.bw      = emit_b ? sum_b[16:0] : bw1;
			st_nxt.stopped = stop2;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/utf16_to_utf8_converter_top.sv =====
// an input transfer's bytes pass the holding stage (pack_s1), then the drain register (drain_q)
// throughput: one output byte per cycle while out_ready is high; each item yields
//   0 to 6 bytes, sent one at a time on the single byte-wide output port
// a one-item holding stage lets the next unit transfer while bytes still drain
// reset: arst_n clears all state but the holding-stage data (pack_s1), capacity returns to 65536
// ----------------------------------------------------------------------------
// utf16_to_utf8_converter_top
// Streaming UTF-16 to UTF-8 converter with output capacity check and
// terminator generation.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_converter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [16:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic        is_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic             truncated
);

	logic [16:0]         capacity_q;
	u16u8_pkg::state_t   st_q;
	u16u8_pkg::state_t   st_nxt;
	u16u8_pkg::pack_t    pack;
	u16u8_pkg::pack_t    pack_s1;
	logic                valid_s1;
	u16u8_pkg::pack_t    drain_q;
	logic [2:0]          idx_q;
	logic                in_xfer;
	logic                out_xfer;
	logic                last_idx;
	logic                drain_free;
	logic                move_s1;

	u16u8_pack u_pack (
		.code_unit (code_unit),
		.is_end    (is_end),
		.capacity  (capacity_q),
		.st        (st_q),
		.st_nxt    (st_nxt),
		.pack      (pack)
	);

	always_comb begin
		out_valid  = drain_q.cnt != 3'd0;
		last_idx   = idx_q == (drain_q.cnt - 3'd1);
		out_xfer   = out_valid && out_ready;
		drain_free = !out_valid || (out_xfer && last_idx);
		move_s1    = valid_s1 && drain_free;
		in_ready   = !valid_s1 || drain_free;
		in_xfer    = in_valid && in_ready;
		out_byte   = drain_q.bytes[idx_q];
		last       = drain_q.is_end && last_idx && out_valid;
		truncated  = drain_q.trunc && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= u16u8_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_xfer) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer && pack.cnt != 3'd0) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pack_s1 <= pack;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= '0;
			idx_q   <= '0;
		end else if (move_s1) begin
			drain_q <= pack_s1;
			idx_q   <= '0;
		end else if (out_xfer) begin
			if (last_idx) begin
				drain_q.cnt <= '0;
				idx_q       <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// byte pointer stays inside the group being sent
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < drain_q.cnt))
		else $error("byte index past end of group");

	// holding stage never keeps an empty group
	a_s1_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (pack_s1.cnt != 3'd0))
		else $error("empty group held");

	// end of string starts a fresh string
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && is_end) |=> (st_q.bw == 17'd0 && !st_q.have && !st_q.stopped))
		else $error("state not cleared after end");

	// terminator transfer is the last byte of its group
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && last) |=> (idx_q == 3'd0))
		else $error("byte pointer not rewound after terminator");

endmodule

`default_nettype wire

// ===== tb/utf16_to_utf8_converter_top_test.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_converter_top_test
// Drives UTF-16 code units and end items into the converter under random
// valid/ready pressure, predicts every UTF-8 byte, terminator and truncated
// flag, and compares each output transfer in order. Capacity is reprogrammed
// between idle phases, from zero up to the full register width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16_to_utf8_converter_top_test;

	typedef struct packed {
		logic [15:0] unit;
		logic        endf;
	} u16_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       cut;
	} utf8_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [16:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit = '0;
	logic        is_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic        truncated;

	u16_item_t   unit_feed[$];
	utf8_out_t   owed_bytes[$];
	logic        in_xfer = 1'b0;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          faults = 0;

	// predictor state
	logic [16:0] cap_bytes = u16u8_pkg::CAP_RESET;
	logic [9:0]  held_hi = '0;
	logic        hi_held = 1'b0;
	logic [16:0] written = '0;
	logic        halted = 1'b0;

	utf16_to_utf8_converter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.code_unit   (code_unit),
		.is_end      (is_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last        (last),
		.truncated   (truncated)
	);

	always #4 clk = ~clk;

	function automatic void emit_point(input logic [20:0] cp);
		int         len;
		logic [7:0] lead;
		logic [7:0] b;
		int         sh;
		if (halted)
			return;
		if (cp < 21'h80) begin
			len = 1;
			lead = 8'h00;
		end else if (cp < 21'h800) begin
			len = 2;
			lead = 8'hC0;
		end else if (cp < u16u8_pkg::SUPP_BASE) begin
			len = 3;
			lead = 8'hE0;
		end else begin
			len = 4;
			lead = 8'hF0;
		end
		if (written + len >= cap_bytes) begin
			halted = 1'b1;
			return;
		end
		written = written + 17'(len);
		for (int i = 0; i < len; i++) begin
			sh = 6 * (len - 1 - i);
			if (i == 0)
				b = lead | 8'(cp >> sh);
			else
				b = 8'h80 | 8'((cp >> sh) & 21'h3F);
			owed_bytes.push_back('{data: b, fin: 1'b0, cut: 1'b0});
		end
	endfunction

	function automatic void transcode_unit(input logic [15:0] unit, input logic endf);
		if (endf) begin
			if (hi_held)
				emit_point(21'(u16u8_pkg::HI_BASE) + 21'(held_hi));
			owed_bytes.push_back('{data: 8'h00, fin: 1'b1, cut: halted});
			held_hi = '0;
			hi_held = 1'b0;
			written = '0;
			halted = 1'b0;
			return;
		end
		if (hi_held) begin
			if (unit >= u16u8_pkg::LO_BASE && unit <= u16u8_pkg::LO_LAST) begin
				hi_held = 1'b0;
				emit_point(21'({held_hi, unit[9:0]}) + u16u8_pkg::SUPP_BASE);
				held_hi = '0;
				return;
			end
			// unpaired high surrogate goes out on its own
			emit_point(21'(u16u8_pkg::HI_BASE) + 21'(held_hi));
			hi_held = 1'b0;
			held_hi = '0;
		end
		if (unit >= u16u8_pkg::HI_BASE && unit <= u16u8_pkg::HI_LAST) begin
			held_hi = unit[9:0];
			hi_held = 1'b1;
			return;
		end
		emit_point(21'(unit));
	endfunction

	function automatic void queue_unit(input logic [15:0] u);
		unit_feed.push_back('{unit: u, endf: 1'b0});
	endfunction

	function automatic void queue_end();
		unit_feed.push_back('{unit: 16'($urandom), endf: 1'b1});
	endfunction

	function automatic int queue_string(input int n);
		int count;
		count = 0;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 9: queue_unit(16'($urandom_range(0, 16'h7F)));
				1: queue_unit(16'($urandom_range(16'h80, 16'h7FF)));
				2: begin
					if ($urandom_range(0, 1))
						queue_unit(16'($urandom_range(16'h800, 16'hD7FF)));
					else
						queue_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
				end
				3, 4: begin
					queue_unit(16'($urandom_range(u16u8_pkg::HI_BASE, u16u8_pkg::HI_LAST)));
					queue_unit(16'($urandom_range(u16u8_pkg::LO_BASE, u16u8_pkg::LO_LAST)));
					count++;
				end
				5: queue_unit(16'($urandom_range(u16u8_pkg::HI_BASE, u16u8_pkg::HI_LAST)));
				6: queue_unit(16'($urandom_range(u16u8_pkg::LO_BASE, u16u8_pkg::LO_LAST)));
				7: queue_unit(16'($urandom));
				default: queue_unit(16'h0000);
			endcase
			count++;
		end
		queue_end();
		return count + 1;
	endfunction

	task automatic settle();
		int guard;
		guard = 0;
		while ((unit_feed.size() != 0 || in_valid || owed_bytes.size() != 0) && guard < 50000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [16:0] value);
		settle();
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cap_bytes = value;
	endtask

	// sender
	always @(negedge clk) begin : drive
		u16_item_t nxt;
		if (!in_valid || in_xfer) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (unit_feed.size() != 0) begin
				nxt = unit_feed.pop_front();
				code_unit <= nxt.unit;
				is_end <= nxt.endf;
				in_valid <= 1'b1;
				if ($urandom_range(0, 99) < gap_pct)
					gap_left = $urandom_range(1, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 5);
		end
	end

	// output check first, then prediction for an input transfer on the same edge
	always @(posedge clk) begin : watch
		utf8_out_t want;
		in_xfer <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (owed_bytes.size() == 0) begin
				if (faults < 10)
					$display("unexpected output transfer: byte %02h last %0b truncated %0b",
						out_byte, last, truncated);
				faults++;
			end else begin
				want = owed_bytes.pop_front();
				if (out_byte !== want.data || last !== want.fin || truncated !== want.cut) begin
					if (faults < 10)
						$display("mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
							want.data, want.fin, want.cut, out_byte, last, truncated);
					faults++;
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			transcode_unit(code_unit, is_end);
	end

	initial begin
		#2_000_000;
		$display("utf16_to_utf8_converter_top_test: FAIL");
		$finish;
	end

	initial begin : stim
		int n;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// code point boundaries, pairs, unpaired and lone surrogates
		queue_unit(16'h0000);
		queue_unit(16'h007F);
		queue_unit(16'h0080);
		queue_unit(16'h07FF);
		queue_unit(16'h0800);
		queue_unit(16'hFFFF);
		queue_unit(16'hD800);
		queue_unit(16'hDC00);
		queue_unit(16'hDBFF);
		queue_unit(16'hDFFF);
		queue_unit(16'hD800);
		queue_unit(16'h0041);
		queue_unit(16'hDBFF);
		queue_unit(16'hD800);
		queue_end();
		queue_unit(16'hDC00);
		queue_unit(16'hDFFF);
		queue_end();

		// truncation right at the fit boundary
		set_capacity(17'd4);
		queue_unit(16'h0041);
		queue_unit(16'h0042);
		queue_unit(16'h0043);
		queue_unit(16'h0044);
		queue_end();

		gap_pct = 30;
		stall_pct = 30;
		set_capacity(17'd1);
		void'(queue_string(3));
		void'(queue_string(0));
		set_capacity(17'd0);
		void'(queue_string(3));
		queue_unit(16'hD900);
		queue_end();

		for (int p = 0; p < 4; p++) begin
			set_capacity(17'($urandom_range(2, 40)));
			gap_pct = (p == 1) ? 0 : (p == 3) ? 15 : 40;
			stall_pct = (p == 2) ? 0 : (p == 3) ? 15 : 40;
			n = 0;
			while (n < 25)
				n += queue_string($urandom_range(0, 10));
		end

		set_capacity(17'h1FFFF);
		gap_pct = 25;
		stall_pct = 25;
		n = 0;
		while (n < 25)
			n += queue_string($urandom_range(0, 12));

		// no idling on either side from here on
		set_capacity(u16u8_pkg::CAP_RESET);
		gap_pct = 0;
		stall_pct = 0;
		n = 0;
		while (n < 25)
			n += queue_string($urandom_range(0, 12));

		settle();
		if (owed_bytes.size() != 0)
			faults++;
		if (faults == 0)
			$display("utf16_to_utf8_converter_top_test: PASS");
		else
			$display("utf16_to_utf8_converter_top_test: FAIL");
		$finish;
	end

endmodule
